// ===== hw/rtl/text_encoding_classifier_assert.svh =====
// Assertion macros shared by the text encoding classifier checkers.
// Depends on nothing; each macro expands to one labeled concurrent assertion.
`ifndef TEXT_ENCODING_CLASSIFIER_ASSERT_SVH
`define TEXT_ENCODING_CLASSIFIER_ASSERT_SVH

// Antecedent implies consequent in the same cycle, checked outside reset.
`define TEC_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Antecedent implies consequent in the following cycle, checked outside reset.
`define TEC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// Antecedent implies consequent in the following cycle, checked also during reset.
`define TEC_ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/tec_pkg.sv =====
// Package for the text encoding classifier: byte constants, result codes,
// and the verdict and scan state structs. Depends on nothing.
package tec_pkg;

   localparam logic [7:0] MASK_TOP2   = 8'hC0;
   localparam logic [7:0] MASK_TOP3   = 8'hE0;
   localparam logic [7:0] MASK_TOP4   = 8'hF0;
   localparam logic [7:0] MASK_TOP5   = 8'hF8;
   localparam logic [7:0] CONT_CODE   = 8'h80;
   localparam logic [7:0] LEAD2_CODE  = 8'hC0;
   localparam logic [7:0] LEAD3_CODE  = 8'hE0;
   localparam logic [7:0] LEAD4_CODE  = 8'hF0;
   localparam logic [7:0] SPACE_CHAR  = 8'h20;
   localparam logic [7:0] TILDE_CHAR  = 8'd126;
   localparam logic [7:0] NUL_CHAR    = 8'd0;
   localparam logic [7:0] TAB_CHAR    = 8'd9;
   localparam logic [7:0] LF_CHAR     = 8'd10;
   localparam logic [7:0] FF_CHAR     = 8'd12;
   localparam logic [7:0] CR_CHAR     = 8'd13;
   localparam logic [7:0] ESC_CHAR    = 8'd27;

   typedef enum logic [1:0] {
      CLASS_UTF8   = 2'd0,
      CLASS_ASCII  = 2'd1,
      CLASS_BINARY = 2'd2
   } text_class_type;

   typedef enum logic [1:0] {
      STYLE_NONE = 2'd0,
      STYLE_CRLF = 2'd1,
      STYLE_CR   = 2'd2
   } line_style_type;

   typedef struct packed {
      text_class_type text_class;
      logic           utf8_ok;
      logic           ascii_ok;
      line_style_type line_style;
   } verdict_type;

   typedef struct packed {
      logic [1:0] pending;
      logic       utf8_failed;
      logic       multibyte_seen;
      logic       ascii_failed;
      logic       printable_seen;
      logic       previous_was_cr;
      logic       bare_cr_seen;
      logic       bare_lf_seen;
      logic       crlf_seen;
   } scan_state_type;

   function automatic logic allowed_control(input logic [7:0] c);
      return (c == LF_CHAR) || (c == CR_CHAR) || (c == TAB_CHAR) ||
             (c == FF_CHAR) || (c == ESC_CHAR);
   endfunction

endpackage

// ===== hw/rtl/tec_scan.sv =====
// Scan state of the classifier: per-byte UTF-8, ASCII and line-ending update
// and the verdict for a final byte. Depends on tec_pkg.
module tec_scan (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [7:0]           byte_in,
   input  logic                 last_in,
   input  logic                 consume,
   output tec_pkg::verdict_type verdict
);

   tec_pkg::scan_state_type state_ff, state_in, nxt;
   logic is_cont;
   logic bad_ctrl;
   logic cr_final;
   logic u_ok;
   logic a_ok;
   tec_pkg::line_style_type style;

   assign is_cont  = (byte_in & tec_pkg::MASK_TOP2) == tec_pkg::CONT_CODE;
   assign bad_ctrl = (byte_in < tec_pkg::SPACE_CHAR) && !tec_pkg::allowed_control(byte_in);

   always_comb begin
      nxt = state_ff;
      // UTF-8 check; a failure is sticky until the buffer ends.
      if (!state_ff.utf8_failed) begin
         if (state_ff.pending != 2'd0) begin
            if (is_cont) begin
               nxt.pending = state_ff.pending - 2'd1;
               if (state_ff.pending == 2'd1) begin
                  nxt.multibyte_seen = 1'b1;
               end
            end else begin
               nxt.utf8_failed = 1'b1;
               nxt.pending     = 2'd0;
            end
         end else if (byte_in < tec_pkg::CONT_CODE) begin
            if (bad_ctrl) begin
               nxt.utf8_failed = 1'b1;
            end
         end else if ((byte_in & tec_pkg::MASK_TOP3) == tec_pkg::LEAD2_CODE) begin
            nxt.pending = 2'd1;
         end else if ((byte_in & tec_pkg::MASK_TOP4) == tec_pkg::LEAD3_CODE) begin
            nxt.pending = 2'd2;
         end else if ((byte_in & tec_pkg::MASK_TOP5) == tec_pkg::LEAD4_CODE) begin
            nxt.pending = 2'd3;
         end else begin
            nxt.utf8_failed = 1'b1;
         end
      end
      // ASCII check. NUL is caught by the control test as well.
      if (bad_ctrl) begin
         nxt.ascii_failed = 1'b1;
      end else if ((byte_in >= tec_pkg::SPACE_CHAR) && (byte_in <= tec_pkg::TILDE_CHAR)) begin
         nxt.printable_seen = 1'b1;
      end
      // Line endings; a CR is judged by the byte after it.
      if (state_ff.previous_was_cr && (byte_in == tec_pkg::LF_CHAR)) begin
         nxt.previous_was_cr = 1'b0;
         nxt.crlf_seen       = 1'b1;
      end else begin
         if (state_ff.previous_was_cr) begin
            nxt.bare_cr_seen = 1'b1;
         end
         nxt.previous_was_cr = (byte_in == tec_pkg::CR_CHAR);
         if (byte_in == tec_pkg::LF_CHAR) begin
            nxt.bare_lf_seen = 1'b1;
         end
      end
   end

   always_comb begin
      cr_final = nxt.bare_cr_seen | nxt.previous_was_cr;
      u_ok     = !nxt.utf8_failed && (nxt.pending == 2'd0) && nxt.multibyte_seen;
      a_ok     = !nxt.ascii_failed && nxt.printable_seen;
      if (nxt.crlf_seen && !cr_final && !nxt.bare_lf_seen) begin
         style = tec_pkg::STYLE_CRLF;
      end else if (cr_final && !nxt.bare_lf_seen && !nxt.crlf_seen) begin
         style = tec_pkg::STYLE_CR;
      end else begin
         style = tec_pkg::STYLE_NONE;
      end
      verdict.utf8_ok  = u_ok;
      verdict.ascii_ok = a_ok;
      if (u_ok) begin
         verdict.text_class = tec_pkg::CLASS_UTF8;
         verdict.line_style = style;
      end else if (a_ok) begin
         verdict.text_class = tec_pkg::CLASS_ASCII;
         verdict.line_style = style;
      end else begin
         verdict.text_class = tec_pkg::CLASS_BINARY;
         verdict.line_style = tec_pkg::STYLE_NONE;
      end
   end

   always_comb begin
      state_in = state_ff;
      if (consume) begin
         state_in = last_in ? '0 : nxt;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== hw/rtl/tec_result.sv =====
// Result register of the classifier: holds one verdict until the receiver
// takes it. Depends on tec_pkg.
module tec_result (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  tec_pkg::verdict_type verdict,
   input  logic                 rsp_stall,
   output logic                 rsp_valid,
   output logic                 free,
   output tec_pkg::verdict_type held
);

   logic                 valid_ff, valid_in;
   tec_pkg::verdict_type held_ff;

   assign free     = !valid_ff || !rsp_stall;
   assign valid_in = load || (valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         held_ff <= verdict;
      end
   end

   assign rsp_valid = valid_ff;
   assign held      = held_ff;

endmodule

// ===== hw/rtl/text_encoding_classifier.sv =====
// Top level of the text encoding classifier: input register, scan state and
// result register. Depends on tec_pkg, tec_scan and tec_result.
//
// Usage: the bytes of a buffer arrive one item per cycle on the req_ channel
// while req_stall is low, req_last_byte marking the final byte. Only the final
// byte yields a result item on the rsp_ channel: the text class (UTF-8, ASCII or
// binary), the two check flags and the line-ending style. The scan state then
// clears, so the next byte starts a new buffer.
// Path: a byte passes through the input register to the scan state; a final
// byte's verdict is loaded into the result register once that register is
// free, and rsp_valid is driven from the result register.
// Throughput: one byte per cycle while no final byte waits in the input
// register. The per-byte update is a few flag and two-bit counter changes
// between the input register and the scan state, so the update never slows it.
// Stall: while rsp_stall holds a waiting verdict, non-final bytes keep flowing;
// a final byte waits in the input register and req_stall rises until the
// verdict register frees up.
// Reset: synchronous, active high; it empties both registers and clears the
// scan state, which is the state of an empty buffer.
module text_encoding_classifier (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_data_byte,
   input  logic       req_last_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [1:0] rsp_text_class,
   output logic       rsp_utf8_ok,
   output logic       rsp_ascii_ok,
   output logic [1:0] rsp_line_style
);

   // Input register.
   logic       stage_valid_ff, stage_valid_in;
   logic [7:0] stage_byte_ff;
   logic       stage_last_ff;

   logic                 out_free;
   logic                 consume;
   logic                 accept;
   tec_pkg::verdict_type verdict;
   tec_pkg::verdict_type held;

   // A non-final byte only updates the scan state, so it never waits on the
   // result side; a final byte needs a free result register.
   assign consume   = stage_valid_ff && (!stage_last_ff || out_free);
   assign req_stall = stage_valid_ff && !consume;
   assign accept    = req_valid && !req_stall;

   assign stage_valid_in = accept || (stage_valid_ff && !consume);

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         stage_byte_ff <= req_data_byte;
         stage_last_ff <= req_last_byte;
      end
   end

   tec_scan u_scan (
      .clock   (clock),
      .reset   (reset),
      .byte_in (stage_byte_ff),
      .last_in (stage_last_ff),
      .consume (consume),
      .verdict (verdict)
   );

   tec_result u_result (
      .clock     (clock),
      .reset     (reset),
      .load      (consume && stage_last_ff),
      .verdict   (verdict),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .free      (out_free),
      .held      (held)
   );

   assign rsp_text_class = held.text_class;
   assign rsp_utf8_ok    = held.utf8_ok;
   assign rsp_ascii_ok   = held.ascii_ok;
   assign rsp_line_style = held.line_style;

endmodule

// ===== hw/rtl/tec_checker.sv =====
// Port-level checks for the text encoding classifier and the bind that
// attaches them. Depends on tec_pkg and text_encoding_classifier_assert.svh.
`include "text_encoding_classifier_assert.svh"

module tec_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [1:0] rsp_text_class,
   input logic       rsp_utf8_ok,
   input logic       rsp_ascii_ok,
   input logic [1:0] rsp_line_style
);

   // A verdict held by the receiver stays valid and keeps its class and line style.
   `TEC_ASSERT_NEXT(a_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_text_class) && $stable(rsp_line_style), "stalled verdict changed")

   // The class follows the flags: UTF-8 exactly when its check passed.
   `TEC_ASSERT_SAME(a_utf8_class, clock, reset, rsp_valid, rsp_utf8_ok == (rsp_text_class == tec_pkg::CLASS_UTF8), "class disagrees with utf8 flag")

   // ASCII class only when the ASCII check passed, binary only when both failed.
   `TEC_ASSERT_SAME(a_fallback, clock, reset, rsp_valid && (rsp_text_class != tec_pkg::CLASS_UTF8), (rsp_ascii_ok == (rsp_text_class == tec_pkg::CLASS_ASCII)) && (rsp_text_class != 2'd3), "class disagrees with ascii flag")

   // Binary data never reports a line style.
   `TEC_ASSERT_SAME(a_binary_style, clock, reset, rsp_valid && (rsp_text_class == tec_pkg::CLASS_BINARY), rsp_line_style == tec_pkg::STYLE_NONE, "binary verdict with line style")

   // Reset empties the result register.
   `TEC_ASSERT_NEXT_ALWAYS(a_reset, clock, reset, !rsp_valid, "result valid after reset")

endmodule

bind text_encoding_classifier tec_checker u_tec_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_text_class (rsp_text_class),
   .rsp_utf8_ok    (rsp_utf8_ok),
   .rsp_ascii_ok   (rsp_ascii_ok),
   .rsp_line_style (rsp_line_style)
);

// ===== tb/tec_verdict_checker.sv =====
// Verdict checker for the text encoding classifier: scans accepted bytes, predicts
// each buffer's verdict and compares it with the result channel. Depends on tec_pkg.
module tec_verdict_checker (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_stall,
   input  logic [7:0] req_data_byte,
   input  logic       req_last_byte,
   input  logic       rsp_valid,
   input  logic       rsp_stall,
   input  logic [1:0] rsp_text_class,
   input  logic       rsp_utf8_ok,
   input  logic       rsp_ascii_ok,
   input  logic [1:0] rsp_line_style,
   output int         mismatch_count,
   output int         verdicts_pending,
   output int         verdicts_checked
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [1:0] owed;
      logic       utf8_bad;
      logic       multibyte;
      logic       ascii_bad;
      logic       printable;
      logic       cr_open;
      logic       saw_bare_cr;
      logic       saw_bare_lf;
      logic       saw_crlf;
   } scan_flags_type;

   scan_flags_type       flags = '0;
   tec_pkg::verdict_type expected_verdicts[$];

   function automatic logic is_text_control(input logic [7:0] c);
      case (c)
         tec_pkg::TAB_CHAR, tec_pkg::LF_CHAR, tec_pkg::FF_CHAR, tec_pkg::CR_CHAR,
         tec_pkg::ESC_CHAR: return 1'b1;
         default: return 1'b0;
      endcase
   endfunction

   // Advances the three scans by one byte.
   function automatic scan_flags_type scan_byte(input scan_flags_type f,
                                                input logic [7:0] c);
      scan_flags_type n;
      n = f;
      if (!n.utf8_bad) begin
         if (n.owed != 2'd0) begin
            if ((c & tec_pkg::MASK_TOP2) == tec_pkg::CONT_CODE) begin
               n.owed = n.owed - 2'd1;
               if (n.owed == 2'd0) n.multibyte = 1'b1;
            end else begin
               n.utf8_bad = 1'b1;
               n.owed     = 2'd0;
            end
         end else if (c == tec_pkg::NUL_CHAR) begin
            n.utf8_bad = 1'b1;
         end else if (c < tec_pkg::CONT_CODE) begin
            if (c < tec_pkg::SPACE_CHAR && !is_text_control(c)) n.utf8_bad = 1'b1;
         end else if ((c & tec_pkg::MASK_TOP3) == tec_pkg::LEAD2_CODE) begin
            n.owed = 2'd1;
         end else if ((c & tec_pkg::MASK_TOP4) == tec_pkg::LEAD3_CODE) begin
            n.owed = 2'd2;
         end else if ((c & tec_pkg::MASK_TOP5) == tec_pkg::LEAD4_CODE) begin
            n.owed = 2'd3;
         end else begin
            n.utf8_bad = 1'b1;
         end
      end

      if (c == tec_pkg::NUL_CHAR) n.ascii_bad = 1'b1;
      else if (c >= tec_pkg::SPACE_CHAR && c <= tec_pkg::TILDE_CHAR) n.printable = 1'b1;
      else if (c < tec_pkg::SPACE_CHAR && !is_text_control(c)) n.ascii_bad = 1'b1;

      // A CR waits one byte to learn whether it opens a CRLF pair.
      if (n.cr_open && c == tec_pkg::LF_CHAR) begin
         n.cr_open  = 1'b0;
         n.saw_crlf = 1'b1;
      end else begin
         if (n.cr_open) n.saw_bare_cr = 1'b1;
         n.cr_open = (c == tec_pkg::CR_CHAR);
         if (c == tec_pkg::LF_CHAR) n.saw_bare_lf = 1'b1;
      end
      return n;
   endfunction

   function automatic tec_pkg::verdict_type judge_buffer(input scan_flags_type f);
      tec_pkg::verdict_type v;
      logic                 bare_cr;
      bare_cr      = f.saw_bare_cr | f.cr_open;
      v.utf8_ok    = !f.utf8_bad && f.owed == 2'd0 && f.multibyte;
      v.ascii_ok   = !f.ascii_bad && f.printable;
      if (f.saw_crlf && !bare_cr && !f.saw_bare_lf) v.line_style = tec_pkg::STYLE_CRLF;
      else if (bare_cr && !f.saw_bare_lf && !f.saw_crlf) v.line_style = tec_pkg::STYLE_CR;
      else v.line_style = tec_pkg::STYLE_NONE;
      if (v.utf8_ok) begin
         v.text_class = tec_pkg::CLASS_UTF8;
      end else if (v.ascii_ok) begin
         v.text_class = tec_pkg::CLASS_ASCII;
      end else begin
         v.text_class = tec_pkg::CLASS_BINARY;
         v.line_style = tec_pkg::STYLE_NONE;
      end
      return v;
   endfunction

   task automatic note_mismatch(input tec_pkg::verdict_type want,
                                input tec_pkg::verdict_type got,
                                input logic none_waiting);
      mismatch_count++;
      if (mismatch_count <= 10) begin
         if (none_waiting)
            $display("[%0t] unexpected verdict: class=%0d utf8=%0d ascii=%0d style=%0d",
                     $realtime, got.text_class, got.utf8_ok, got.ascii_ok, got.line_style);
         else
            $display("[%0t] verdict mismatch: expected class=%0d utf8=%0d ascii=%0d style=%0d, %s",
                     $realtime, want.text_class, want.utf8_ok, want.ascii_ok, want.line_style,
                     $sformatf("got class=%0d utf8=%0d ascii=%0d style=%0d", got.text_class,
                               got.utf8_ok, got.ascii_ok, got.line_style));
      end
   endtask

   always @(posedge clock) begin
      tec_pkg::verdict_type got;
      tec_pkg::verdict_type want;
      if (reset) begin
         flags            = '0;
         mismatch_count   = 0;
         verdicts_pending = 0;
         verdicts_checked = 0;
         expected_verdicts.delete();
      end else begin
         // Check the result side first; a verdict never leaves in the cycle its byte enters.
         if (rsp_valid && !rsp_stall) begin
            got.text_class = tec_pkg::text_class_type'(rsp_text_class);
            got.utf8_ok    = rsp_utf8_ok;
            got.ascii_ok   = rsp_ascii_ok;
            got.line_style = tec_pkg::line_style_type'(rsp_line_style);
            if (expected_verdicts.size() == 0) begin
               note_mismatch(got, got, 1'b1);
            end else begin
               want = expected_verdicts.pop_front();
               verdicts_checked++;
               if (got !== want) note_mismatch(want, got, 1'b0);
            end
         end
         if (req_valid && !req_stall) begin
            flags = scan_byte(flags, req_data_byte);
            if (req_last_byte) begin
               expected_verdicts.push_back(judge_buffer(flags));
               flags = '0;
            end
         end
         verdicts_pending = expected_verdicts.size();
      end
   end

endmodule

// ===== tb/text_encoding_classifier_tb.sv =====
// Testbench top for the text encoding classifier: clock, reset, byte stimulus and
// the final verdict. Depends on tec_pkg, the block and tec_verdict_checker.
module text_encoding_classifier_tb;
   timeunit 1ns;
   timeprecision 1ps;

   typedef logic [7:0] byte_queue_type[$];

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_data_byte = 8'd0;
   logic       req_last_byte = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [1:0] rsp_text_class;
   logic       rsp_utf8_ok;
   logic       rsp_ascii_ok;
   logic [1:0] rsp_line_style;

   int mismatch_count;
   int verdicts_pending;
   int verdicts_checked;

   // Idle and stall odds, in percent, for the current phase.
   int idle_pct  = 0;
   int stall_pct = 0;
   int bytes_sent   = 0;
   int buffers_sent = 0;

   always #5 clock = ~clock;

   text_encoding_classifier dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data_byte (req_data_byte),
      .req_last_byte (req_last_byte),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_text_class(rsp_text_class),
      .rsp_utf8_ok   (rsp_utf8_ok),
      .rsp_ascii_ok  (rsp_ascii_ok),
      .rsp_line_style(rsp_line_style)
   );

   tec_verdict_checker checker_i (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_data_byte   (req_data_byte),
      .req_last_byte   (req_last_byte),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_text_class  (rsp_text_class),
      .rsp_utf8_ok     (rsp_utf8_ok),
      .rsp_ascii_ok    (rsp_ascii_ok),
      .rsp_line_style  (rsp_line_style),
      .mismatch_count  (mismatch_count),
      .verdicts_pending(verdicts_pending),
      .verdicts_checked(verdicts_checked)
   );

   // The receiver stalls at random with the odds of the current phase.
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   // Offers one byte and waits until it is taken. All inputs change only at the
   // rising edge, so the stall seen at the falling edge holds through the next edge.
   task automatic send_byte(input logic [7:0] value, input logic is_last);
      logic taken;
      while ($urandom_range(99) < idle_pct) begin
         req_valid     <= 1'b0;
         req_data_byte <= 8'($urandom_range(255));
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_data_byte <= value;
      req_last_byte <= is_last;
      taken = 1'b0;
      while (!taken) begin
         @(negedge clock);
         taken = !req_stall;
         @(posedge clock);
      end
      bytes_sent++;
   endtask

   task automatic send_buffer(input byte_queue_type bytes);
      foreach (bytes[i]) send_byte(bytes[i], i == bytes.size() - 1);
      buffers_sent++;
   endtask

   // The sender goes quiet until every expected verdict has come back.
   task automatic drain_verdicts();
      req_valid <= 1'b0;
      do @(negedge clock); while (verdicts_pending != 0);
      @(posedge clock);
   endtask

   // Appends a lead byte and the given number of continuations; a full sequence
   // owes lead-length minus one continuations, fewer make a truncated one.
   task automatic push_sequence(ref byte_queue_type q, input int lead_len, input int conts);
      case (lead_len)
         2:       q.push_back(tec_pkg::LEAD2_CODE | 8'($urandom_range(31)));
         3:       q.push_back(tec_pkg::LEAD3_CODE | 8'($urandom_range(15)));
         default: q.push_back(tec_pkg::LEAD4_CODE | 8'($urandom_range(7)));
      endcase
      repeat (conts) q.push_back(tec_pkg::CONT_CODE | 8'($urandom_range(63)));
   endtask

   function automatic logic [7:0] pick_control();
      case ($urandom_range(4))
         0:       return tec_pkg::TAB_CHAR;
         1:       return tec_pkg::LF_CHAR;
         2:       return tec_pkg::FF_CHAR;
         3:       return tec_pkg::CR_CHAR;
         default: return tec_pkg::ESC_CHAR;
      endcase
   endfunction

   function automatic logic [7:0] pick_printable();
      return 8'($urandom_range(tec_pkg::SPACE_CHAR, tec_pkg::TILDE_CHAR));
   endfunction

   // Builds one random buffer. Most are well-formed text with random content,
   // the rest are truncated, corrupted or plain noise.
   task automatic make_buffer(output byte_queue_type q);
      int kind;
      int len;
      int lead_len;
      int pick;
      q.delete();
      pick = $urandom_range(99);
      if (pick < 35)      kind = 0;   // UTF-8 text
      else if (pick < 50) kind = 1;   // ASCII text with DEL and high bytes
      else if (pick < 65) kind = 2;   // line-ending mixes
      else if (pick < 75) kind = 3;   // UTF-8 cut off at the end
      else if (pick < 85) kind = 4;   // noise
      else                kind = 5;   // UTF-8 with one byte spoiled
      len = ($urandom_range(19) == 0) ? $urandom_range(16, 40) : $urandom_range(1, 10);
      for (int i = 0; i < len; i++) begin
         case (kind)
            0, 3, 5: begin
               case ($urandom_range(9))
                  0, 1, 2, 3: q.push_back(pick_printable());
                  4, 5: begin
                     lead_len = $urandom_range(2, 4);
                     push_sequence(q, lead_len, lead_len - 1);
                  end
                  6: begin
                     q.push_back(tec_pkg::CR_CHAR);
                     q.push_back(tec_pkg::LF_CHAR);
                  end
                  7: q.push_back(pick_control());
                  8: q.push_back(8'h7F);
                  default: q.push_back(tec_pkg::SPACE_CHAR);
               endcase
            end
            1: begin
               case ($urandom_range(9))
                  0, 1, 2, 3, 4: q.push_back(pick_printable());
                  5: q.push_back(8'h7F);
                  6, 7: q.push_back(8'($urandom_range(128, 255)));
                  default: q.push_back(pick_control());
               endcase
            end
            2: begin
               case ($urandom_range(5))
                  0, 1: q.push_back(pick_printable());
                  2: q.push_back(tec_pkg::CR_CHAR);
                  3: q.push_back(tec_pkg::LF_CHAR);
                  default: begin
                     q.push_back(tec_pkg::CR_CHAR);
                     q.push_back(tec_pkg::LF_CHAR);
                  end
               endcase
            end
            default: q.push_back(8'($urandom_range(255)));
         endcase
      end
      if (kind == 3) begin
         lead_len = $urandom_range(2, 4);
         push_sequence(q, lead_len, $urandom_range(0, lead_len - 2));
      end else if (kind == 5) begin
         q[$urandom_range(q.size() - 1)] = 8'($urandom_range(255));
      end
   endtask

   // Generous ceiling; a correct run needs a small fraction of it.
   initial begin
      #2_000_000;
      $display("FAILURE");
      $finish;
   end

   initial begin
      int             idle_tab[4]  = '{0, 69, 0, 29};
      int             stall_tab[4] = '{0, 0, 69, 29};
      int             phase_start;
      int             failures;
      byte_queue_type buffer_bytes;

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed buffers: single bytes, extremes, every verdict and each corner
      // of the sequence and line-ending rules.
      send_buffer('{8'h41});                              // lone printable byte
      send_buffer('{8'h00});                              // NUL
      send_buffer('{8'hFF});                              // invalid lead, no printable
      send_buffer('{tec_pkg::CR_CHAR});                   // trailing CR only
      send_buffer('{8'h80, 8'h7F});                       // stray continuation, DEL
      send_buffer('{8'hC3, 8'hA9});                       // two-byte sequence
      send_buffer('{8'hE2, 8'h82});                       // truncated three-byte
      send_buffer('{8'hF0, 8'h9F, 8'h98, 8'h80});         // four-byte sequence
      send_buffer('{8'h61, tec_pkg::CR_CHAR, tec_pkg::LF_CHAR});   // CRLF only
      // Bare CR then CRLF.
      send_buffer('{8'h61, tec_pkg::CR_CHAR, tec_pkg::CR_CHAR, tec_pkg::LF_CHAR});
      // Bare CR style after the allowed controls.
      send_buffer('{8'h7E, tec_pkg::ESC_CHAR, tec_pkg::TAB_CHAR, tec_pkg::FF_CHAR,
                    tec_pkg::CR_CHAR});
      send_buffer('{8'h20, 8'h1F});                       // refused control byte
      drain_verdicts();

      // Random buffers in four phases of idling and stalling, draining in between.
      for (int p = 0; p < 4; p++) begin
         idle_pct    = idle_tab[p];
         stall_pct   = stall_tab[p];
         phase_start = bytes_sent;
         while (bytes_sent - phase_start < 300) begin
            make_buffer(buffer_bytes);
            send_buffer(buffer_bytes);
         end
         drain_verdicts();
      end

      repeat (10) @(posedge clock);
      failures = mismatch_count + verdicts_pending;
      $display("Sent %0d bytes in %0d buffers under four idle/stall phases.",
               bytes_sent, buffers_sent);
      $display("Compared %0d verdicts; %0d mismatches, %0d left unanswered.",
               verdicts_checked, mismatch_count, verdicts_pending);
      if (failures == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/tec_pkg.sv
hw/rtl/tec_scan.sv
hw/rtl/tec_result.sv
hw/rtl/text_encoding_classifier.sv
hw/rtl/tec_checker.sv
tb/tec_verdict_checker.sv
tb/text_encoding_classifier_tb.sv
